/* hdl/usbsr_pkg.sv */
// Package with the shared types and constants of the USB setup request responder.
package usbsr_pkg;

    localparam int LOG_BUFFER_BYTES = 256;

    localparam logic [15:0] VENDOR_ID_RST      = 16'h9999;
    localparam logic [15:0] PRODUCT_ID_RST     = 16'h9999;
    localparam logic [15:0] DEVICE_RELEASE_RST = 16'h0100;
    localparam logic [6:0]  EP0_MAX_PACKET_RST = 7'd64;
    localparam logic [7:0]  MAX_POWER_RST      = 8'd250;
    localparam logic [7:0]  LOG_CODE_RST       = 8'h99;

    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;

    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_VENDOR   = 2'd2;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;

    localparam logic [4:0] DEVICE_DESC_SIZE = 5'd18;
    localparam logic [4:0] CONFIG_DESC_SIZE = 5'd9;

    typedef enum logic [2:0] {
        CFG_VENDOR_ID      = 3'd0,
        CFG_PRODUCT_ID     = 3'd1,
        CFG_DEVICE_RELEASE = 3'd2,
        CFG_EP0_MAX_PACKET = 3'd3,
        CFG_MAX_POWER      = 3'd4,
        CFG_LOG_CODE       = 3'd5
    } t_cfg_index;

    typedef enum logic [2:0] {
        ACT_STALL = 3'd0,
        ACT_ACK   = 3'd1,
        ACT_DESC  = 3'd2,
        ACT_LOG   = 3'd3,
        ACT_RESET = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_SEND   = 2'd2
    } t_state;

    typedef struct packed {
        logic        is_bus_reset;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
        logic [8:0]  log_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [8:0] transfer_length;
        logic [6:0] device_address;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic decode;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

/* hdl/usb_setup_request_responder_top.sv */
// Top level of the USB setup request responder.
//
//  Channel  Direction  Handshake          Payload
//  in       input      i_in_valid/stall   t_in_item: one decoded setup request or bus reset
//  out      output     o_out_valid/stall  t_out_item: one result beat
//  cfg      input      i_cfg_valid/ready  3-bit register index, 16-bit data
//
// A request is captured in the idle state, decoded in the decode state and sent from the send
// state as its result beats (1, or up to 18 descriptor bytes), one beat per cycle unless the
// output stalls, all sequenced by the controller state machine.
// Reset is synchronous; it restores the register defaults and clears the address.
// A stall on the output holds the current beat; no new request is taken until the last
// beat has left.
module usb_setup_request_responder_top #(
    parameter int LOG_BUFFER_BYTES = usbsr_pkg::LOG_BUFFER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  usbsr_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output usbsr_pkg::t_out_item o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    usbsr_pkg::t_cmd    cmd;
    usbsr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    usbsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    usbsr_dp #(
        .LOG_BUFFER_BYTES (LOG_BUFFER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule

/* hdl/usbsr_ctrl.sv */
// Controller state machine that sequences capture, decode and result beats.
module usbsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  usbsr_pkg::t_status i_status,
    output usbsr_pkg::t_cmd   o_cmd
);

    usbsr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usbsr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            usbsr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = usbsr_pkg::ST_DECODE;
                end
            end
            usbsr_pkg::ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = usbsr_pkg::ST_SEND;
            end
            usbsr_pkg::ST_SEND: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_status.last) begin
                        n_state = usbsr_pkg::ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = usbsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/usbsr_dp.sv */
// Datapath with configuration registers, request decode, address register and descriptor bytes.
module usbsr_dp #(
    parameter int LOG_BUFFER_BYTES = usbsr_pkg::LOG_BUFFER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  usbsr_pkg::t_in_item  i_in,
    input  usbsr_pkg::t_cmd      i_cmd,
    output usbsr_pkg::t_status   o_status,
    output usbsr_pkg::t_out_item o_out
);

    localparam logic [8:0] LOG_CAP = (LOG_BUFFER_BYTES < 256) ? 9'(LOG_BUFFER_BYTES) : 9'd256;

    logic [15:0] r_vendor_id;
    logic [15:0] r_product_id;
    logic [15:0] r_device_release;
    logic [6:0]  r_ep0_max_packet;
    logic [7:0]  r_max_power;
    logic [7:0]  r_log_code;

    usbsr_pkg::t_in_item r_req;
    usbsr_pkg::t_action  r_action, n_action;
    logic [8:0]          r_tlen, n_tlen;
    logic                r_is_config, n_is_config;
    logic [6:0]          r_addr, n_addr;
    logic [4:0]          r_idx;

    logic [4:0] desc_size;
    logic [4:0] desc_len;
    logic [8:0] log_len;
    logic [7:0] desc_byte;
    logic       has_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor_id      <= usbsr_pkg::VENDOR_ID_RST;
            r_product_id     <= usbsr_pkg::PRODUCT_ID_RST;
            r_device_release <= usbsr_pkg::DEVICE_RELEASE_RST;
            r_ep0_max_packet <= usbsr_pkg::EP0_MAX_PACKET_RST;
            r_max_power      <= usbsr_pkg::MAX_POWER_RST;
            r_log_code       <= usbsr_pkg::LOG_CODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                usbsr_pkg::CFG_VENDOR_ID:      r_vendor_id      <= i_cfg_data;
                usbsr_pkg::CFG_PRODUCT_ID:     r_product_id     <= i_cfg_data;
                usbsr_pkg::CFG_DEVICE_RELEASE: r_device_release <= i_cfg_data;
                usbsr_pkg::CFG_EP0_MAX_PACKET: r_ep0_max_packet <= i_cfg_data[6:0];
                usbsr_pkg::CFG_MAX_POWER:      r_max_power      <= i_cfg_data[7:0];
                usbsr_pkg::CFG_LOG_CODE:       r_log_code       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        desc_size = (r_req.request_value[15:8] == usbsr_pkg::DESC_DEVICE) ?
                    usbsr_pkg::DEVICE_DESC_SIZE : usbsr_pkg::CONFIG_DESC_SIZE;
        desc_len  = (r_req.request_length < {11'd0, desc_size}) ?
                    r_req.request_length[4:0] : desc_size;
        log_len   = (r_req.log_length > LOG_CAP) ? LOG_CAP : r_req.log_length;
    end

    always_comb begin
        n_action    = usbsr_pkg::ACT_STALL;
        n_tlen      = '0;
        n_is_config = 1'b0;
        n_addr      = r_addr;
        priority if (r_req.is_bus_reset) begin
            n_action = usbsr_pkg::ACT_RESET;
            n_addr   = '0;
        end else if (r_req.request_type[6:5] == usbsr_pkg::KIND_STANDARD) begin
            priority if (r_req.request_code == usbsr_pkg::REQ_SET_ADDRESS) begin
                n_action = usbsr_pkg::ACT_ACK;
                n_addr   = r_req.request_value[6:0];
            end else if (r_req.request_code == usbsr_pkg::REQ_GET_DESCRIPTOR) begin
                if (r_req.request_value[15:8] == usbsr_pkg::DESC_DEVICE ||
                    r_req.request_value[15:8] == usbsr_pkg::DESC_CONFIG) begin
                    n_action    = usbsr_pkg::ACT_DESC;
                    n_tlen      = {4'd0, desc_len};
                    n_is_config = (r_req.request_value[15:8] == usbsr_pkg::DESC_CONFIG);
                end
            end else if (r_req.request_code == usbsr_pkg::REQ_SET_CONFIG) begin
                n_action = usbsr_pkg::ACT_ACK;
            end else begin
                n_action = usbsr_pkg::ACT_STALL;
            end
        end else if (r_req.request_type[6:5] == usbsr_pkg::KIND_VENDOR) begin
            if (r_req.request_type[7] && r_req.request_type[4:0] == 5'd0 &&
                r_req.request_code == r_log_code) begin
                n_action = usbsr_pkg::ACT_LOG;
                n_tlen   = log_len;
            end
        end else begin
            n_action = usbsr_pkg::ACT_STALL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.decode) begin
            r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in;
        end
        if (i_cmd.decode) begin
            r_action    <= n_action;
            r_tlen      <= n_tlen;
            r_is_config <= n_is_config;
            r_idx       <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 5'd1;
        end
    end

    always_comb begin
        desc_byte = 8'd0;
        if (r_is_config) begin
            unique case (r_idx)
                5'd0:    desc_byte = 8'd9;
                5'd1:    desc_byte = 8'd2;
                5'd2:    desc_byte = 8'd9;
                5'd5:    desc_byte = 8'd1;
                5'd7:    desc_byte = 8'hC0;
                5'd8:    desc_byte = r_max_power;
                default: desc_byte = 8'd0;
            endcase
        end else begin
            unique case (r_idx)
                5'd0:    desc_byte = 8'd18;
                5'd1:    desc_byte = 8'd1;
                5'd3:    desc_byte = 8'h02;
                5'd7:    desc_byte = {1'b0, r_ep0_max_packet};
                5'd8:    desc_byte = r_vendor_id[7:0];
                5'd9:    desc_byte = r_vendor_id[15:8];
                5'd10:   desc_byte = r_product_id[7:0];
                5'd11:   desc_byte = r_product_id[15:8];
                5'd12:   desc_byte = r_device_release[7:0];
                5'd13:   desc_byte = r_device_release[15:8];
                5'd17:   desc_byte = 8'd1;
                default: desc_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        has_bytes             = (r_action == usbsr_pkg::ACT_DESC) && (r_tlen != 9'd0);
        o_status.last         = has_bytes ? (r_idx + 5'd1 == r_tlen[4:0]) : 1'b1;
        o_out.action          = r_action;
        o_out.data_byte       = has_bytes ? desc_byte : 8'd0;
        o_out.byte_valid      = has_bytes;
        o_out.transfer_length = r_tlen;
        o_out.device_address  = r_addr;
        o_out.last            = o_status.last;
    end

endmodule

/* hdl/usbsr_checker.sv */
// Port-level checker for the USB setup request responder, with its bind statement.
module usbsr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input usbsr_pkg::t_out_item o_out
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a request is still in work");

    a_no_input_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result beats are pending");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.last) |=> !o_out_valid)
        else $error("beat shown after the last beat of a request");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out.last) |=>
        (o_out_valid && o_out.action == usbsr_pkg::ACT_DESC))
        else $error("descriptor burst broken off before its last beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat changed");

endmodule

bind usb_setup_request_responder_top usbsr_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

/* test/tb_usb_setup_request_responder_top.sv */
`timescale 1ns / 100ps
// Testbench that checks the USB setup request responder beat by beat against its own predictor.
module tb_usb_setup_request_responder_top;

    localparam int LIMIT_NS       = 2_000_000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_PHASE   = 24;

    localparam logic [1:0] KIND_CLASS    = 2'd1;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [7:0] REQ_GET_STATUS = 8'h00;
    localparam logic [7:0] REQ_UNKNOWN    = 8'hFF;
    localparam logic [7:0] DESC_STRING    = 8'd3;
    localparam logic [7:0] CFG_ATTRIBUTES = 8'hC0;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    usbsr_pkg::t_in_item  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    usbsr_pkg::t_out_item o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    logic [15:0] cfg_vid      = usbsr_pkg::VENDOR_ID_RST;
    logic [15:0] cfg_pid      = usbsr_pkg::PRODUCT_ID_RST;
    logic [15:0] cfg_rel      = usbsr_pkg::DEVICE_RELEASE_RST;
    logic [6:0]  cfg_ep0      = usbsr_pkg::EP0_MAX_PACKET_RST;
    logic [7:0]  cfg_power    = usbsr_pkg::MAX_POWER_RST;
    logic [7:0]  cfg_log_code = usbsr_pkg::LOG_CODE_RST;
    logic [6:0]  shadow_addr  = '0;

    usbsr_pkg::t_out_item pending_beats[$];
    usbsr_pkg::t_out_item head_beat;
    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holdoff_reqs  = 0;
    int holdoff_seen  = 0;
    int holdoff_cnt   = 0;

    usb_setup_request_responder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void push_beat(usbsr_pkg::t_action act, logic [7:0] data, logic valid,
                                      logic [8:0] len, logic last);
        usbsr_pkg::t_out_item b;
        b.action          = act;
        b.data_byte       = data;
        b.byte_valid      = valid;
        b.transfer_length = len;
        b.device_address  = shadow_addr;
        b.last            = last;
        pending_beats.push_back(b);
    endfunction

    function automatic void compute_response(usbsr_pkg::t_in_item it);
        logic [7:0] desc [0:17];
        logic [8:0] ll;
        int size;
        int n;
        int i;
        size = 0;
        if (it.is_bus_reset) begin
            shadow_addr = '0;
            push_beat(usbsr_pkg::ACT_RESET, 8'h00, 1'b0, 9'd0, 1'b1);
        end else if (it.request_type[6:5] == usbsr_pkg::KIND_STANDARD) begin
            if (it.request_code == usbsr_pkg::REQ_SET_ADDRESS) begin
                shadow_addr = it.request_value[6:0];
                push_beat(usbsr_pkg::ACT_ACK, 8'h00, 1'b0, 9'd0, 1'b1);
            end else if (it.request_code == usbsr_pkg::REQ_GET_DESCRIPTOR) begin
                if (it.request_value[15:8] == usbsr_pkg::DESC_DEVICE) begin
                    desc[0]  = 8'd18;
                    desc[1]  = usbsr_pkg::DESC_DEVICE;
                    desc[2]  = 8'h00;
                    desc[3]  = 8'h02;
                    desc[4]  = 8'h00;
                    desc[5]  = 8'h00;
                    desc[6]  = 8'h00;
                    desc[7]  = {1'b0, cfg_ep0};
                    desc[8]  = cfg_vid[7:0];
                    desc[9]  = cfg_vid[15:8];
                    desc[10] = cfg_pid[7:0];
                    desc[11] = cfg_pid[15:8];
                    desc[12] = cfg_rel[7:0];
                    desc[13] = cfg_rel[15:8];
                    desc[14] = 8'h00;
                    desc[15] = 8'h00;
                    desc[16] = 8'h00;
                    desc[17] = 8'h01;
                    size = int'(usbsr_pkg::DEVICE_DESC_SIZE);
                end else if (it.request_value[15:8] == usbsr_pkg::DESC_CONFIG) begin
                    desc[0] = 8'd9;
                    desc[1] = usbsr_pkg::DESC_CONFIG;
                    desc[2] = 8'd9;
                    desc[3] = 8'h00;
                    desc[4] = 8'h00;
                    desc[5] = 8'h01;
                    desc[6] = 8'h00;
                    desc[7] = CFG_ATTRIBUTES;
                    desc[8] = cfg_power;
                    size = int'(usbsr_pkg::CONFIG_DESC_SIZE);
                end
                if (size == 0) begin
                    push_beat(usbsr_pkg::ACT_STALL, 8'h00, 1'b0, 9'd0, 1'b1);
                end else begin
                    n = (int'(it.request_length) < size) ? int'(it.request_length) : size;
                    if (n == 0) begin
                        push_beat(usbsr_pkg::ACT_DESC, 8'h00, 1'b0, 9'd0, 1'b1);
                    end else begin
                        for (i = 0; i < n; i++) begin
                            push_beat(usbsr_pkg::ACT_DESC, desc[i], 1'b1, 9'(n), i == n - 1);
                        end
                    end
                end
            end else if (it.request_code == usbsr_pkg::REQ_SET_CONFIG) begin
                push_beat(usbsr_pkg::ACT_ACK, 8'h00, 1'b0, 9'd0, 1'b1);
            end else begin
                push_beat(usbsr_pkg::ACT_STALL, 8'h00, 1'b0, 9'd0, 1'b1);
            end
        end else if (it.request_type[6:5] == usbsr_pkg::KIND_VENDOR && it.request_type[7]
                     && it.request_type[4:0] == 5'd0 && it.request_code == cfg_log_code) begin
            ll = it.log_length;
            if (int'(ll) > usbsr_pkg::LOG_BUFFER_BYTES) begin
                ll = 9'(usbsr_pkg::LOG_BUFFER_BYTES);
            end
            if (ll > 9'd256) begin
                ll = 9'd256;
            end
            push_beat(usbsr_pkg::ACT_LOG, 8'h00, 1'b0, ll, 1'b1);
        end else begin
            push_beat(usbsr_pkg::ACT_STALL, 8'h00, 1'b0, 9'd0, 1'b1);
        end
    endfunction

    function automatic logic [7:0] req_type(logic dir_in, logic [1:0] kind, logic [4:0] rcpt);
        return {dir_in, kind, rcpt};
    endfunction

    function automatic usbsr_pkg::t_in_item setup_item(logic [7:0] rtype, logic [7:0] code,
                                                       logic [15:0] value, logic [15:0] len,
                                                       logic [8:0] loglen);
        usbsr_pkg::t_in_item it;
        it.is_bus_reset   = 1'b0;
        it.request_type   = rtype;
        it.request_code   = code;
        it.request_value  = value;
        it.request_length = len;
        it.log_length     = loglen;
        return it;
    endfunction

    function automatic usbsr_pkg::t_in_item bus_reset_item(logic fill);
        usbsr_pkg::t_in_item it;
        it = {($bits(usbsr_pkg::t_in_item)){fill}};
        it.is_bus_reset = 1'b1;
        return it;
    endfunction

    function automatic usbsr_pkg::t_in_item rand_request();
        usbsr_pkg::t_in_item it;
        logic [63:0] raw;
        int pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(usbsr_pkg::t_in_item)-1:0];
        it.is_bus_reset = 1'b0;
        pick = $urandom_range(99);
        if (pick < 8) begin
            it.is_bus_reset = 1'b1;
        end else if (pick < 40) begin
            it.request_type[6:5] = usbsr_pkg::KIND_STANDARD;
            it.request_code = usbsr_pkg::REQ_GET_DESCRIPTOR;
            if ($urandom_range(9) != 0) begin
                it.request_value[15:8] = $urandom_range(1) ? usbsr_pkg::DESC_DEVICE
                                                           : usbsr_pkg::DESC_CONFIG;
            end
            if ($urandom_range(3) != 0) begin
                it.request_length = 16'($urandom_range(20));
            end
        end else if (pick < 55) begin
            it.request_type[6:5] = usbsr_pkg::KIND_STANDARD;
            it.request_code = usbsr_pkg::REQ_SET_ADDRESS;
        end else if (pick < 62) begin
            it.request_type[6:5] = usbsr_pkg::KIND_STANDARD;
            it.request_code = usbsr_pkg::REQ_SET_CONFIG;
        end else if (pick < 82) begin
            it.request_type = req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0);
            it.request_code = cfg_log_code;
            if ($urandom_range(5) == 0) begin
                it.request_type[7] = 1'b0;
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input usbsr_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        compute_response(it);
    endtask

    task automatic set_registers(input logic [15:0] vid, input logic [15:0] pid,
                                 input logic [15:0] rel, input logic [15:0] ep0,
                                 input logic [15:0] power, input logic [15:0] code);
        logic [15:0] vals [0:5];
        usbsr_pkg::t_cfg_index idx;
        int k;
        vals = '{vid, pid, rel, ep0, power, code};
        for (k = 0; k < 6; k++) begin
            idx = usbsr_pkg::t_cfg_index'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            case (idx)
                usbsr_pkg::CFG_VENDOR_ID:      cfg_vid = vals[k];
                usbsr_pkg::CFG_PRODUCT_ID:     cfg_pid = vals[k];
                usbsr_pkg::CFG_DEVICE_RELEASE: cfg_rel = vals[k];
                usbsr_pkg::CFG_EP0_MAX_PACKET: cfg_ep0 = vals[k][6:0];
                usbsr_pkg::CFG_MAX_POWER:      cfg_power = vals[k][7:0];
                usbsr_pkg::CFG_LOG_CODE:       cfg_log_code = vals[k][7:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic probe_descriptors(input logic [8:0] loglen);
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_STANDARD, 5'd0),
                             usbsr_pkg::REQ_GET_DESCRIPTOR,
                             {usbsr_pkg::DESC_DEVICE, 8'h00}, 16'hFFFF, 9'd0));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_STANDARD, 5'd0),
                             usbsr_pkg::REQ_GET_DESCRIPTOR,
                             {usbsr_pkg::DESC_CONFIG, 8'h00}, 16'hFFFF, 9'd0));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0), cfg_log_code,
                             16'h0000, 16'h0000, loglen));
    endtask

    task automatic test_directed_defaults();
        logic [7:0] std_in;
        logic [7:0] get_desc;
        logic [7:0] dev;
        logic [7:0] cfg;
        std_in   = req_type(1'b1, usbsr_pkg::KIND_STANDARD, 5'd0);
        get_desc = usbsr_pkg::REQ_GET_DESCRIPTOR;
        dev      = usbsr_pkg::DESC_DEVICE;
        cfg      = usbsr_pkg::DESC_CONFIG;
        send_idle_pct = 7;
        recv_idle_pct = 76;
        send_item(bus_reset_item(1'b0));
        send_item(setup_item(std_in, get_desc, {dev, 8'h00}, 16'hFFFF, 9'd0));
        send_item(setup_item(std_in, get_desc, {dev, 8'h00}, 16'd18, 9'd0));
        send_item(setup_item(std_in, get_desc, {dev, 8'hFF}, 16'd17, 9'd0));
        send_item(setup_item(std_in, get_desc, {dev, 8'h00}, 16'd1, 9'd0));
        send_item(setup_item(std_in, get_desc, {dev, 8'h00}, 16'd0, 9'd0));
        send_item(setup_item(std_in, get_desc, {cfg, 8'h00}, 16'd9, 9'd0));
        send_item(setup_item(std_in, get_desc, {cfg, 8'h00}, 16'd8, 9'd0));
        send_item(setup_item(std_in, get_desc, {cfg, 8'h00}, 16'd0, 9'd0));
        send_item(setup_item(std_in, get_desc, {DESC_STRING, 8'h00}, 16'd64, 9'd0));
        send_item(setup_item(std_in, get_desc, 16'hFFFF, 16'hFFFF, 9'h1FF));
        send_item(setup_item(req_type(1'b0, usbsr_pkg::KIND_STANDARD, 5'h1F),
                             usbsr_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 9'h1FF));
        send_item(setup_item(std_in, get_desc, {cfg, 8'h00}, 16'hFFFF, 9'd0));
        send_item(setup_item(req_type(1'b0, usbsr_pkg::KIND_STANDARD, 5'd0),
                             usbsr_pkg::REQ_SET_CONFIG, 16'h0001, 16'h0000, 9'd0));
        send_item(setup_item(std_in, REQ_GET_STATUS, 16'h0000, 16'd2, 9'd0));
        send_item(setup_item(std_in, REQ_UNKNOWN, 16'h0000, 16'd2, 9'd0));
        send_item(setup_item(req_type(1'b1, KIND_CLASS, 5'd0), get_desc,
                             {dev, 8'h00}, 16'd18, 9'd0));
        send_item(setup_item(req_type(1'b1, KIND_RESERVED, 5'd0), get_desc,
                             {dev, 8'h00}, 16'd18, 9'd0));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0), cfg_log_code,
                             16'h0000, 16'h0000, 9'd0));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0), cfg_log_code,
                             16'hFFFF, 16'd4, 9'd256));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0), cfg_log_code,
                             16'h0000, 16'hFFFF, 9'h1FF));
        send_item(setup_item(req_type(1'b0, usbsr_pkg::KIND_VENDOR, 5'd0), cfg_log_code,
                             16'h0000, 16'h0000, 9'd10));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd1), cfg_log_code,
                             16'h0000, 16'h0000, 9'd10));
        send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0),
                             cfg_log_code ^ 8'h01, 16'h0000, 16'h0000, 9'd10));
        send_item(bus_reset_item(1'b1));
        send_item(setup_item(std_in, get_desc, {cfg, 8'h00}, 16'd3, 9'd0));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        send_idle_pct = 7;
        recv_idle_pct = 76;
        set_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        probe_descriptors(9'd300);
        wait_idle();
        set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        probe_descriptors(9'd255);
        wait_idle();
        set_registers(16'h1234, 16'h5678, 16'h9ABC, 16'd8, 16'd1, 16'h005A);
        probe_descriptors(9'd1);
        wait_idle();
        set_registers(usbsr_pkg::VENDOR_ID_RST, usbsr_pkg::PRODUCT_ID_RST,
                      usbsr_pkg::DEVICE_RELEASE_RST, 16'd64,
                      16'(usbsr_pkg::MAX_POWER_RST), 16'(usbsr_pkg::LOG_CODE_RST));
        probe_descriptors(9'd256);
        wait_idle();
    endtask

    task automatic test_random_requests();
        int phase;
        int n;
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 7 : 0;
            set_registers(16'($urandom), 16'($urandom), 16'($urandom),
                          $urandom_range(1) ? 16'($urandom_range(64, 8)) : 16'($urandom),
                          16'($urandom), 16'($urandom));
            for (n = 0; n < RANDOM_PHASE; n++) begin
                send_item(rand_request());
            end
            wait_idle();
        end
    endtask

    task automatic test_output_holdoff();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_reqs <= holdoff_reqs + 1;
        for (n = 0; n < 12; n++) begin
            if (n % 3 == 2) begin
                send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_VENDOR, 5'd0),
                                     cfg_log_code, 16'h0000, 16'h0000, 9'($urandom)));
            end else begin
                send_item(setup_item(req_type(1'b1, usbsr_pkg::KIND_STANDARD, 5'd0),
                                     usbsr_pkg::REQ_GET_DESCRIPTOR,
                                     {usbsr_pkg::DESC_DEVICE, 8'h00},
                                     16'($urandom_range(18, 1)), 9'd0));
            end
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (holdoff_reqs != holdoff_seen) begin
            holdoff_seen <= holdoff_reqs;
            holdoff_cnt <= HOLDOFF_CYCLES;
            i_out_stall <= 1'b1;
        end else if (holdoff_cnt != 0) begin
            holdoff_cnt <= holdoff_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat, action", int'(o_out.action), -1);
            end else begin
                head_beat = pending_beats.pop_front();
                if (o_out.action != head_beat.action)
                    report_mismatch("action", int'(o_out.action), int'(head_beat.action));
                if (o_out.data_byte != head_beat.data_byte)
                    report_mismatch("data_byte", int'(o_out.data_byte),
                                    int'(head_beat.data_byte));
                if (o_out.byte_valid != head_beat.byte_valid)
                    report_mismatch("byte_valid", int'(o_out.byte_valid),
                                    int'(head_beat.byte_valid));
                if (o_out.transfer_length != head_beat.transfer_length)
                    report_mismatch("transfer_length", int'(o_out.transfer_length),
                                    int'(head_beat.transfer_length));
                if (o_out.device_address != head_beat.device_address)
                    report_mismatch("device_address", int'(o_out.device_address),
                                    int'(head_beat.device_address));
                if (o_out.last != head_beat.last)
                    report_mismatch("last", int'(o_out.last), int'(head_beat.last));
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_register_extremes();
        test_random_requests();
        test_output_holdoff();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
hdl/usbsr_pkg.sv
hdl/usbsr_ctrl.sv
hdl/usbsr_dp.sv
hdl/usb_setup_request_responder_top.sv
hdl/usbsr_checker.sv
test/tb_usb_setup_request_responder_top.sv
